// File: design/eeg_pkg.sv
// Shared constants and controller/datapath handshake types for the extended Euclid unit.
package eeg_pkg;

    // Default operand width; the top level hands this down as a parameter.
    localparam int OPERAND_WIDTH_DEF = 31;

    // Fixed widths of the result fields.
    localparam int GCD_W  = 31;
    localparam int COEF_W = 32;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // Capture and order a new operand pair.
        logic start;     // Seed the divider from the current remainder pair.
        logic div_step;  // One restoring division step.
        logic mul_a;     // Quotient times the first lower coefficient.
        logic mul_b;     // Quotient times the second lower coefficient.
        logic update;    // Shift the remainder and coefficient pairs.
        logic finish;    // Write the result word into the output register.
    } eeg_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic operand_zero;  // Either operand at the input is zero.
        logic div_last;      // The divider is on its final step.
        logic rem_zero;      // The finished remainder is zero.
    } eeg_status_t;

endpackage

// File: design/eeg_if.sv
// Valid/ready channel interfaces for the operand and result words.
interface eeg_in_if #(
    parameter int OPERAND_WIDTH = eeg_pkg::OPERAND_WIDTH_DEF
);
    logic                     valid;
    logic                     ready;
    logic [OPERAND_WIDTH-1:0] first_value;
    logic [OPERAND_WIDTH-1:0] second_value;

    modport source (output valid, output first_value, output second_value, input ready);
    modport sink   (input valid, input first_value, input second_value, output ready);
endinterface

interface eeg_out_if;
    import eeg_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [GCD_W-1:0]         gcd_value;
    logic signed [COEF_W-1:0] coef_first;
    logic signed [COEF_W-1:0] coef_second;
    logic                     bad_operand;

    modport source (output valid, output gcd_value, output coef_first, output coef_second,
                    output bad_operand, input ready);
    modport sink   (input valid, input gcd_value, input coef_first, input coef_second,
                    input bad_operand, output ready);
endinterface

// File: design/eeg_ctrl.sv
// Sequencing state machine for the extended Euclid unit.
module eeg_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  eeg_pkg::eeg_status_t status,
    output eeg_pkg::eeg_cmd_t    cmd
);
    import eeg_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_START  = 8'b0000_0010,
        S_DIV    = 8'b0000_0100,
        S_CHECK  = 8'b0000_1000,
        S_MULA   = 8'b0001_0000,
        S_MULB   = 8'b0010_0000,
        S_UPDATE = 8'b0100_0000,
        S_FINISH = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    // The output register can take a new word when empty or being drained.
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.operand_zero ? S_FINISH : S_START;
                end
            end
            S_START:
            begin
                cmd.start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = status.rem_zero ? S_FINISH : S_MULA;
            end
            S_MULA:
            begin
                cmd.mul_a  = 1'b1;
                state_next = S_MULB;
            end
            S_MULB:
            begin
                cmd.mul_b  = 1'b1;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_START;
            end
            S_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: design/eeg_datapath.sv
// Remainder, coefficient, divider and multiplier registers of the extended Euclid unit.
module eeg_datapath #(
    parameter int OPERAND_WIDTH = eeg_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic [OPERAND_WIDTH-1:0]          first_value,
    input  logic [OPERAND_WIDTH-1:0]          second_value,
    input  eeg_pkg::eeg_cmd_t                 cmd,
    output eeg_pkg::eeg_status_t              status,
    output logic [eeg_pkg::GCD_W-1:0]         gcd_value,
    output logic signed [eeg_pkg::COEF_W-1:0] coef_first,
    output logic signed [eeg_pkg::COEF_W-1:0] coef_second,
    output logic                              bad_operand
);
    import eeg_pkg::*;

    localparam int W     = OPERAND_WIDTH;
    localparam int CNT_W = $clog2(W);

    // Remainder pair and the matching coefficient pairs (a: first operand, b: second).
    logic [W-1:0]      rhi_reg, rlo_reg;
    logic [COEF_W-1:0] fahi_reg, falo_reg, fbhi_reg, fblo_reg;
    logic              bad_reg;

    // Restoring divider.
    logic [W-1:0]      rem_reg, quo_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [W:0]        shifted, diff;
    logic              fits;

    // Shared multiplier and its product registers.
    logic [63:0]       quo_ext;
    logic [COEF_W-1:0] quo_trunc, mul_src, product;
    logic [COEF_W-1:0] pa_reg, pb_reg;

    // Output word registers.
    logic [GCD_W-1:0]  gcd_reg;
    logic [COEF_W-1:0] ca_reg, cb_reg;
    logic              bad_out_reg;
    logic [63:0]       rlo_ext;

    assign status.operand_zero = (first_value == '0) || (second_value == '0);
    assign status.div_last     = (cnt_reg == CNT_W'(W - 1));
    assign status.rem_zero     = (rem_reg == '0);

    // One division step: shift in the next dividend bit and subtract if it fits.
    assign shifted = {rem_reg, quo_reg[W-1]};
    assign diff    = shifted - {1'b0, rlo_reg};
    assign fits    = (shifted >= {1'b0, rlo_reg});

    // Coefficients wrap at their field width, so the quotient is cut to match.
    assign quo_ext   = 64'(quo_reg);
    assign quo_trunc = quo_ext[COEF_W-1:0];
    assign mul_src   = cmd.mul_a ? falo_reg : fblo_reg;
    assign product   = mul_src * quo_trunc;

    assign rlo_ext = 64'(rlo_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bad_reg <= status.operand_zero;
            if (first_value > second_value)
            begin
                rhi_reg  <= first_value;
                rlo_reg  <= second_value;
                fahi_reg <= COEF_W'(1);
                falo_reg <= '0;
                fbhi_reg <= '0;
                fblo_reg <= COEF_W'(1);
            end
            else
            begin
                rhi_reg  <= second_value;
                rlo_reg  <= first_value;
                fahi_reg <= '0;
                falo_reg <= COEF_W'(1);
                fbhi_reg <= COEF_W'(1);
                fblo_reg <= '0;
            end
        end
        else if (cmd.update)
        begin
            rhi_reg  <= rlo_reg;
            rlo_reg  <= rem_reg;
            fahi_reg <= falo_reg;
            falo_reg <= fahi_reg - pa_reg;
            fbhi_reg <= fblo_reg;
            fblo_reg <= fbhi_reg - pb_reg;
        end

        if (cmd.start)
        begin
            rem_reg <= '0;
            quo_reg <= rhi_reg;
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= fits ? diff[W-1:0] : shifted[W-1:0];
            quo_reg <= {quo_reg[W-2:0], fits};
            cnt_reg <= cnt_reg + CNT_W'(1);
        end

        if (cmd.mul_a)
        begin
            pa_reg <= product;
        end
        if (cmd.mul_b)
        begin
            pb_reg <= product;
        end

        if (cmd.finish)
        begin
            bad_out_reg <= bad_reg;
            if (bad_reg)
            begin
                gcd_reg <= '0;
                ca_reg  <= '0;
                cb_reg  <= '0;
            end
            else
            begin
                gcd_reg <= rlo_ext[GCD_W-1:0];
                ca_reg  <= falo_reg;
                cb_reg  <= fblo_reg;
            end
        end
    end

    assign gcd_value   = gcd_reg;
    assign coef_first  = ca_reg;
    assign coef_second = cb_reg;
    assign bad_operand = bad_out_reg;

endmodule

// File: design/extended_euclid_gcd_unit.sv
// Top level of the extended Euclid unit: greatest common divisor with Bezout coefficients.
//
//   Channel   Direction  Payload
//   operands  in         first_value, second_value (OPERAND_WIDTH bits each, unsigned)
//   results   out        gcd_value (31 b), coef_first, coef_second (32 b signed), bad_operand
//
// One operand word is worked on at a time. The larger operand is divided by the smaller
// one with a restoring divider that retires one quotient bit per cycle. Each quotient
// and remainder step passes the start, divide and check states, and every step that
// leaves a nonzero remainder then runs the shared coefficient multiplier for each lower
// coefficient in turn and the register update. A word with a zero operand goes straight
// from acceptance to the finish state.
// Reset clears the controller and the output valid flag; the datapath needs no reset.
// A finished result waits in the output register while the next operand word is accepted;
// the unit only stalls in its finish state while that register is full and not drained.
module extended_euclid_gcd_unit #(
    parameter int OPERAND_WIDTH = eeg_pkg::OPERAND_WIDTH_DEF
) (
    input logic      clk,
    input logic      rst_n,
    eeg_in_if.sink   operands,
    eeg_out_if.source results
);
    import eeg_pkg::*;

    // Commands and status between the controller and the datapath.
    eeg_cmd_t    cmd;
    eeg_status_t status;

    // The controller owns both handshakes; the datapath owns every payload register.
    eeg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (operands.valid),
        .in_ready  (operands.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .status    (status),
        .cmd       (cmd)
    );

    eeg_datapath #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .first_value  (operands.first_value),
        .second_value (operands.second_value),
        .cmd          (cmd),
        .status       (status),
        .gcd_value    (results.gcd_value),
        .coef_first   (results.coef_first),
        .coef_second  (results.coef_second),
        .bad_operand  (results.bad_operand)
    );

endmodule

// File: bench/bezout_checker.sv
// Checker that predicts gcd and Bezout coefficients per operand word and compares the results.
`timescale 1ns / 100ps
module bezout_checker #(
    parameter int OPERAND_WIDTH = eeg_pkg::OPERAND_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    eeg_in_if    operands,
    eeg_out_if   results,
    output int   fail_count,
    output int   outstanding
);

    typedef struct packed {
        logic [eeg_pkg::GCD_W-1:0]  gcd_value;
        logic [eeg_pkg::COEF_W-1:0] coef_first;
        logic [eeg_pkg::COEF_W-1:0] coef_second;
        logic                       bad_operand;
    } bezout_t;

    bezout_t expected_bezout[$];

    initial begin
        fail_count  = 0;
        outstanding = 0;
    end

    // Remainder and coefficient pairs run in 64-bit wrapping arithmetic; the last nonzero
    // remainder is the gcd and its coefficients are kept to their low 32 bits.
    function automatic bezout_t bezout_predict(input logic [OPERAND_WIDTH-1:0] first,
                                               input logic [OPERAND_WIDTH-1:0] second);
        logic [63:0] rem_hi;
        logic [63:0] rem_lo;
        logic [63:0] fa_hi;
        logic [63:0] fa_lo;
        logic [63:0] fb_hi;
        logic [63:0] fb_lo;
        logic [63:0] quot;
        logic [63:0] rem;
        logic [63:0] next_a;
        logic [63:0] next_b;
        bezout_t     res;
        res = '0;
        if (first == '0 || second == '0) begin
            res.bad_operand = 1'b1;
            return res;
        end
        if (first > second) begin
            rem_hi = 64'(first);
            rem_lo = 64'(second);
            fa_hi  = 64'd1;
            fa_lo  = 64'd0;
            fb_hi  = 64'd0;
            fb_lo  = 64'd1;
        end else begin
            rem_hi = 64'(second);
            rem_lo = 64'(first);
            fa_hi  = 64'd0;
            fa_lo  = 64'd1;
            fb_hi  = 64'd1;
            fb_lo  = 64'd0;
        end
        while (1'b1) begin
            quot = rem_hi / rem_lo;
            rem  = rem_hi - quot * rem_lo;
            if (rem == 64'd0)
                break;
            next_a = fa_hi - quot * fa_lo;
            next_b = fb_hi - quot * fb_lo;
            rem_hi = rem_lo;
            rem_lo = rem;
            fa_hi  = fa_lo;
            fa_lo  = next_a;
            fb_hi  = fb_lo;
            fb_lo  = next_b;
        end
        res.gcd_value   = rem_lo[eeg_pkg::GCD_W-1:0];
        res.coef_first  = fa_lo[eeg_pkg::COEF_W-1:0];
        res.coef_second = fb_lo[eeg_pkg::COEF_W-1:0];
        return res;
    endfunction

    task automatic flag_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
        fail_count++;
        $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, field, want, got);
    endtask

    always @(posedge clk) begin
        bezout_t got;
        bezout_t want;
        if (rst_n) begin
            // Results are retired before new words are queued, so a word and a result
            // taken on the same edge never pair up with each other.
            if (results.valid && results.ready) begin
                got.gcd_value   = results.gcd_value;
                got.coef_first  = results.coef_first;
                got.coef_second = results.coef_second;
                got.bad_operand = results.bad_operand;
                if (expected_bezout.size() == 0) begin
                    fail_count++;
                    $display("%0t: result word with nothing expected, expected none, got 0x%0h",
                             $time, got);
                end else begin
                    want = expected_bezout.pop_front();
                    if (got.gcd_value != want.gcd_value)
                        flag_field("gcd_value", 64'(want.gcd_value), 64'(got.gcd_value));
                    if (got.coef_first != want.coef_first)
                        flag_field("coef_first", 64'(want.coef_first), 64'(got.coef_first));
                    if (got.coef_second != want.coef_second)
                        flag_field("coef_second", 64'(want.coef_second),
                                   64'(got.coef_second));
                    if (got.bad_operand != want.bad_operand)
                        flag_field("bad_operand", 64'(want.bad_operand),
                                   64'(got.bad_operand));
                end
            end
            if (operands.valid && operands.ready)
                expected_bezout.push_back(bezout_predict(operands.first_value,
                                                         operands.second_value));
            outstanding = expected_bezout.size();
        end
    end

endmodule

// File: bench/extended_euclid_gcd_unit_tb.sv
// Top of the extended Euclid unit bench: clock, reset, operand and result traffic, verdict.
`timescale 1ns / 100ps
module extended_euclid_gcd_unit_tb;
    import eeg_pkg::*;

    localparam int OW = OPERAND_WIDTH_DEF;

    // Total operand words, directed ones included.
    localparam int WORD_COUNT = 850;

    // After this many words the sender stops and waits for every result to drain.
    localparam int DRAIN_AT = 200;

    // After this many words the receiver holds off for a long stretch, while the sender
    // keeps offering a run of small words without gaps so that the unit backs up.
    localparam int HOLD_AT     = 400;
    localparam int HOLD_WORDS  = 12;
    localparam int HOLD_CYCLES = 2500;

    // A word of Fibonacci-adjacent operands needs about 45 divide steps, the longest run of
    // any word; the long hold-off and the widest sender gap each stay below this limit, even
    // with such a word added, so this limit only trips on a unit that has stopped.
    localparam int IDLE_LIMIT    = 20000;
    localparam int SETTLE_CYCLES = 100;

    localparam logic [OW-1:0] MAX_OPERAND = '1;

    // Directed words: zero operands, equal operands, exact multiples in both orders,
    // the slowest coprime pair both ways, alternating bit patterns and plain coprimes.
    localparam int DIRECTED_COUNT = 22;
    localparam logic [2*OW-1:0] DIRECTED_PAIRS [DIRECTED_COUNT] = '{
        {31'd0,          31'd0},
        {31'd0,          31'd12345},
        {MAX_OPERAND,    31'd0},
        {31'd0,          31'd1},
        {31'd1,          31'd0},
        {31'd1,          31'd1},
        {MAX_OPERAND,    MAX_OPERAND},
        {31'd12345,      31'd12345},
        {31'd1,          MAX_OPERAND},
        {MAX_OPERAND,    31'd1},
        {31'd6,          31'd42},
        {31'd1000,       31'd250},
        {31'd1836311903, 31'd1134903170},
        {31'd1134903170, 31'd1836311903},
        {MAX_OPERAND,    31'd2147483646},
        {31'h2AAAAAAA,   31'h55555555},
        {31'h55555555,   31'h2AAAAAAA},
        {31'd1073741824, 31'd805306368},
        {31'd2,          31'd3},
        {31'd1,          31'd2},
        {31'd1000000007, 31'd998244353},
        {31'd196608,     31'd327680}
    };

    // Receiver stall patterns.
    typedef enum int {
        RX_OPEN,    // always ready
        RX_COIN,    // ready half the time at random
        RX_SPARSE,  // ready one cycle in four
        RX_JITTER   // mostly ready with short random stalls
    } rx_mode_e;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    eeg_in_if #(.OPERAND_WIDTH(OW)) operand_ch ();
    eeg_out_if                      result_ch ();

    int fail_count;
    int outstanding;
    int words_sent = 0;
    int burst_left = 0;

    extended_euclid_gcd_unit #(
        .OPERAND_WIDTH(OW)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .operands (operand_ch),
        .results  (result_ch)
    );

    bezout_checker #(
        .OPERAND_WIDTH(OW)
    ) u_bezout_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .operands    (operand_ch),
        .results     (result_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #10 clk = ~clk;

    // Offers one operand word at a falling edge and returns once it has been taken.
    // Outside a steady run, the sender works in bursts: when a burst is used up it drops
    // valid for a random gap, mostly short and sometimes long enough to let the unit go
    // idle, then starts a fresh burst. Valid stays high between words of one burst, so
    // each falling edge carries at most one assignment to it.
    task automatic offer_word(input logic [OW-1:0] first, input logic [OW-1:0] second,
                              input bit steady);
        @(negedge clk);
        if (!steady && burst_left == 0) begin
            operand_ch.valid <= 1'b0;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(50, 600)) @(negedge clk);
            else
                repeat ($urandom_range(1, 12)) @(negedge clk);
            // About one burst in eight is a long one, giving stretches with no idling at all.
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 16);
        end
        operand_ch.valid        <= 1'b1;
        operand_ch.first_value  <= first;
        operand_ch.second_value <= second;
        if (burst_left > 0)
            burst_left--;
        do
            @(posedge clk);
        while (!operand_ch.ready);
        words_sent++;
    endtask

    // Sender: reset, the directed words, then the random mix.
    initial begin
        logic [OW-1:0] a;
        logic [OW-1:0] b;
        logic [OW-1:0] swap;
        logic [63:0]   prod;
        logic [63:0]   fib_lo;
        logic [63:0]   fib_hi;
        logic [63:0]   fib_next;
        int            pick;
        operand_ch.valid        = 1'b0;
        operand_ch.first_value  = '0;
        operand_ch.second_value = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_COUNT; i++)
            offer_word(DIRECTED_PAIRS[i][2*OW-1:OW], DIRECTED_PAIRS[i][OW-1:0], 1'b0);

        for (int i = DIRECTED_COUNT; i < WORD_COUNT; i++) begin
            // Pause once with valid low until every expected result has come back.
            if (i == DRAIN_AT) begin
                @(negedge clk);
                operand_ch.valid <= 1'b0;
                while (outstanding != 0)
                    @(negedge clk);
            end

            pick = $urandom_range(0, 99);
            if (i >= HOLD_AT && i < HOLD_AT + HOLD_WORDS) begin
                // Short words so that the unit finishes quickly and then backs up.
                a = OW'($urandom_range(1, 255));
                b = OW'($urandom_range(1, 255));
            end else if (pick < 50) begin
                // Full-width operands; every bit of both fields toggles here.
                a = OW'($urandom());
                b = OW'($urandom());
            end else if (pick < 63) begin
                a = OW'($urandom_range(1, 255));
                b = OW'($urandom_range(1, 255));
            end else if (pick < 76) begin
                // A shared factor, so the gcd is well above one.
                prod = 64'($urandom_range(2, 4095));
                a    = OW'(prod * 64'($urandom_range(1, 524287)));
                b    = OW'(prod * 64'($urandom_range(1, 524287)));
            end else if (pick < 84) begin
                // One operand an exact multiple of the other, in either order.
                b = OW'($urandom_range(1, 65535));
                a = OW'(64'(b) * 64'($urandom_range(1, 32767)));
                if ($urandom_range(0, 1) == 1) begin
                    swap = a;
                    a    = b;
                    b    = swap;
                end
            end else if (pick < 89) begin
                a = OW'($urandom());
                if (a == '0)
                    a = MAX_OPERAND;
                b = a;
            end else if (pick < 94) begin
                // Zero on one side or both.
                a = OW'($urandom());
                b = OW'($urandom());
                case ($urandom_range(0, 2))
                    0:       a = '0;
                    1:       b = '0;
                    default:
                    begin
                        a = '0;
                        b = '0;
                    end
                endcase
            end else begin
                // Neighboring Fibonacci numbers: the longest runs of divide steps.
                fib_lo = 64'd1;
                fib_hi = 64'd1;
                repeat ($urandom_range(1, 44)) begin
                    fib_next = fib_lo + fib_hi;
                    fib_lo   = fib_hi;
                    fib_hi   = fib_next;
                end
                a = OW'(fib_hi);
                b = OW'(fib_lo);
                if ($urandom_range(0, 1) == 1) begin
                    swap = a;
                    a    = b;
                    b    = swap;
                end
            end
            offer_word(a, b, i >= HOLD_AT && i < HOLD_AT + HOLD_WORDS);
        end

        @(negedge clk);
        operand_ch.valid <= 1'b0;

        // Wait for the last results, then give the unit time to show any stray word.
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("[extended_euclid_gcd_unit] OK");
        else
            $display("[extended_euclid_gcd_unit] ERROR");
        $finish;
    end

    // Receiver: changes ready at falling edges, cycling through stall patterns of random
    // length. Once the sender has passed the hold point, ready is held low for a long
    // stretch counted here, so the output register fills and the unit stalls its input.
    initial begin
        rx_mode_e mode;
        int       mode_left;
        bit       hold_done;
        mode            = RX_OPEN;
        mode_left       = 0;
        hold_done       = 1'b0;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (!hold_done && words_sent >= HOLD_AT) begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = rx_mode_e'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 400);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:   result_ch.ready <= 1'b1;
                    RX_COIN:   result_ch.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: result_ch.ready <= (mode_left % 4 == 0);
                    default:   result_ch.ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // Watchdog: ends the run if no word moves on either channel for too long.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((operand_ch.valid && operand_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
        $display("[extended_euclid_gcd_unit] ERROR");
        $finish;
    end

endmodule
